/* rtl/core/source_comment_directive_stripper_top_defines.svh */
// assertion macros shared by the stripper rtl
`ifndef SOURCE_COMMENT_DIRECTIVE_STRIPPER_TOP_DEFINES_SVH
`define SOURCE_COMMENT_DIRECTIVE_STRIPPER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SCDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SCDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/scds_pkg.sv */
// shared types, character codes and keyword table for the comment stripper
package scds_pkg;

  typedef enum logic [2:0] {
    MODE_LINE_START = 3'd0,
    MODE_PREFIX     = 3'd1,
    MODE_BODY       = 3'd2,
    MODE_DROP       = 3'd3,
    MODE_BLOCK      = 3'd4
  } mode_t;

  localparam logic [3:0] PREFIX_LEN = 4'd15;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] matched;
    logic       slash;
    logic       star;
  } scan_t;

  localparam scan_t SCAN_RESET = '{mode: MODE_LINE_START, matched: 4'd0,
                                   slash: 1'b0, star: 1'b0};

  // results caused by one input byte, in output order:
  // released keyword bytes, held slash, the byte itself, slash flushed at end
  typedef struct packed {
    logic [3:0] prefix_cnt;
    logic       pre_slash;
    logic       has_byte;
    logic [7:0] data;
    logic       post_slash;
    logic       fin;
    logic [4:0] total;
  } run_t;

  // "using namespace"
  function automatic logic [7:0] using_ns_byte(input logic [3:0] k);
    logic [7:0] ch;
    unique case (k)
      4'd0:    ch = 8'h75;
      4'd1:    ch = 8'h73;
      4'd2:    ch = 8'h69;
      4'd3:    ch = 8'h6E;
      4'd4:    ch = 8'h67;
      4'd5:    ch = 8'h20;
      4'd6:    ch = 8'h6E;
      4'd7:    ch = 8'h61;
      4'd8:    ch = 8'h6D;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h73;
      4'd11:   ch = 8'h70;
      4'd12:   ch = 8'h61;
      4'd13:   ch = 8'h63;
      4'd14:   ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/source_comment_directive_stripper_top.sv */
// Comment and directive stripper for C/C++ text, one byte per transaction. Bytes pass
// through except preprocessor lines, "using namespace" lines, line comments and block
// comments; newlines are always kept, also those inside block comments. Each input
// transaction causes zero to fifteen output transactions (or one bare end marker when
// final_byte is set and nothing else comes out). A byte is taken every cycle as long as
// each byte gives at most one result and the output is not stalled; a byte that gives
// more results holds the input until its last result is handed on, because the result
// sequencer hands one result a cycle to the output register unless the output stalls.
// Path to the first result: input register, scanner into run register, output register.
`include "source_comment_directive_stripper_top_defines.svh"

module source_comment_directive_stripper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic       end_of_text
);

  logic            held_valid;
  logic [7:0]      held_byte;
  logic            held_final;
  scds_pkg::scan_t scan;
  scds_pkg::scan_t scan_next;
  scds_pkg::run_t  run;
  logic            load_ok;
  logic            take;

  assign take       = held_valid && load_ok;
  assign item_stall = held_valid && !load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_byte  <= in_byte;
      held_final <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= scds_pkg::SCAN_RESET;
    end else if (take) begin
      scan <= scan_next;
    end
  end

  scds_step u_step (
    .in_byte    (held_byte),
    .final_byte (held_final),
    .cur        (scan),
    .nxt        (scan_next),
    .run        (run)
  );

  scds_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .run_in       (run),
    .load_ok      (load_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last_of_run  (last_of_run),
    .end_of_text  (end_of_text)
  );

  `SCDS_ASSERT_NEXT(a_fin_resets, take && held_final, scan == scds_pkg::SCAN_RESET, "scan state not cleared after end of text")
  `SCDS_ASSERT_NOW(a_slash_in_body, scan.slash, scan.mode == scds_pkg::MODE_BODY, "slash held outside body text")

endmodule

/* rtl/core/scds_step.sv */
// per-byte scanner: next scan state and the run of results for one input byte
module scds_step (
  input  logic [7:0]           in_byte,
  input  logic                 final_byte,
  input  scds_pkg::scan_t      cur,
  output scds_pkg::scan_t      nxt,
  output scds_pkg::run_t       run
);

  logic       do_body;
  logic       is_nl;
  logic [3:0] p;
  logic       pre;
  logic       has;
  logic       post;
  logic [4:0] sum;
  scds_pkg::scan_t st;

  assign is_nl = (in_byte == scds_pkg::CH_NL);

  always_comb begin
    st      = cur;
    p       = 4'd0;
    pre     = 1'b0;
    has     = 1'b0;
    post    = 1'b0;
    do_body = 1'b0;
    unique case (cur.mode)
      scds_pkg::MODE_LINE_START: begin
        if (in_byte == scds_pkg::CH_SPACE || in_byte == scds_pkg::CH_TAB || is_nl) begin
          has = 1'b1;
        end else if (in_byte == scds_pkg::CH_HASH) begin
          st.mode = scds_pkg::MODE_DROP;
        end else if (in_byte == scds_pkg::using_ns_byte(4'd0)) begin
          st.mode    = scds_pkg::MODE_PREFIX;
          st.matched = 4'd1;
        end else begin
          do_body = 1'b1;
        end
      end
      scds_pkg::MODE_PREFIX: begin
        if (cur.matched < scds_pkg::PREFIX_LEN &&
            in_byte == scds_pkg::using_ns_byte(cur.matched)) begin
          st.matched = cur.matched + 4'd1;
          if (st.matched == scds_pkg::PREFIX_LEN) begin
            st.matched = 4'd0;
            st.mode    = scds_pkg::MODE_DROP;
          end
        end else begin
          // keyword broke off: release what was held, then treat byte as text
          p          = cur.matched;
          st.matched = 4'd0;
          do_body    = 1'b1;
        end
      end
      scds_pkg::MODE_DROP: begin
        if (is_nl) begin
          has     = 1'b1;
          st.mode = scds_pkg::MODE_LINE_START;
        end
      end
      scds_pkg::MODE_BLOCK: begin
        if (is_nl) begin
          has = 1'b1;
        end
        if (cur.star && in_byte == scds_pkg::CH_SLASH) begin
          st.star = 1'b0;
          st.mode = scds_pkg::MODE_BODY;
        end else begin
          st.star = (in_byte == scds_pkg::CH_STAR);
        end
      end
      default: begin
        do_body = 1'b1;
      end
    endcase

    if (do_body) begin
      st.mode = scds_pkg::MODE_BODY;
      if (cur.slash) begin
        st.slash = 1'b0;
        if (in_byte == scds_pkg::CH_SLASH) begin
          st.mode = scds_pkg::MODE_DROP;
        end else if (in_byte == scds_pkg::CH_STAR) begin
          st.mode = scds_pkg::MODE_BLOCK;
          st.star = 1'b0;
        end else begin
          pre = 1'b1;
          has = 1'b1;
          if (is_nl) begin
            st.mode = scds_pkg::MODE_LINE_START;
          end
        end
      end else if (in_byte == scds_pkg::CH_SLASH) begin
        st.slash = 1'b1;
      end else begin
        has = 1'b1;
        if (is_nl) begin
          st.mode = scds_pkg::MODE_LINE_START;
        end
      end
    end

    // end of text flushes a pending keyword prefix and a pending slash
    if (final_byte) begin
      if (st.mode == scds_pkg::MODE_PREFIX) begin
        p = st.matched;
      end
      post = st.slash;
      st   = scds_pkg::SCAN_RESET;
    end

    sum = {1'b0, p} + {4'd0, pre} + {4'd0, has} + {4'd0, post};

    nxt            = st;
    run.prefix_cnt = p;
    run.pre_slash  = pre;
    run.has_byte   = has;
    run.data       = in_byte;
    run.post_slash = post;
    run.fin        = final_byte;
    run.total      = sum + {4'd0, final_byte && (sum == 5'd0)};
  end

endmodule

/* rtl/core/scds_emit.sv */
// result sequencer: walks one run a result per cycle, while the output is not stalled, into the output register
`include "source_comment_directive_stripper_top_defines.svh"

module scds_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  scds_pkg::run_t      run_in,
  output logic                load_ok,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                last_of_run,
  output logic                end_of_text
);

  logic           busy;
  logic           busy_next;
  scds_pkg::run_t run;
  logic [4:0]     idx;
  logic [4:0]     idx_next;

  logic           out_free;
  logic           fire;
  logic           is_last;
  logic [4:0]     a_pre;
  logic [4:0]     a_byte;
  logic [4:0]     a_post;
  logic [7:0]     el_byte;
  logic           el_valid;

  assign out_free = !result_valid || !result_stall;
  assign fire     = busy && out_free;
  assign is_last  = (idx == run.total - 5'd1);
  assign load_ok  = !busy || (fire && is_last);

  assign a_pre  = {1'b0, run.prefix_cnt};
  assign a_byte = a_pre + {4'd0, run.pre_slash};
  assign a_post = a_byte + {4'd0, run.has_byte};

  always_comb begin
    el_byte  = 8'h00;
    el_valid = 1'b1;
    priority if (idx < a_pre) begin
      el_byte = scds_pkg::using_ns_byte(idx[3:0]);
    end else if (run.pre_slash && idx == a_pre) begin
      el_byte = scds_pkg::CH_SLASH;
    end else if (run.has_byte && idx == a_byte) begin
      el_byte = run.data;
    end else if (run.post_slash && idx == a_post) begin
      el_byte = scds_pkg::CH_SLASH;
    end else begin
      // bare end marker
      el_valid = 1'b0;
    end
  end

  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    if (fire) begin
      if (is_last) begin
        busy_next = 1'b0;
      end else begin
        idx_next = idx + 5'd1;
      end
    end
    if (load) begin
      busy_next = (run_in.total != 5'd0);
      idx_next  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 5'd0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= el_byte;
      byte_valid  <= el_valid;
      last_of_run <= is_last;
      end_of_text <= run.fin && is_last;
    end
  end

  `SCDS_ASSERT_NOW(a_idx_in_run, busy, idx < run.total, "result index past end of run")
  `SCDS_ASSERT_NOW(a_eot_last, result_valid && end_of_text, last_of_run, "end of text not on last result")
  `SCDS_ASSERT_NOW(a_bare_eot, result_valid && !byte_valid, end_of_text && out_byte == 8'h00, "bare result that is not an end marker")

endmodule
